### hdl/rau_pkg.sv
// Shared types and command codes of the rational arithmetic unit.
package rau_pkg;

   localparam int DATA_W = 32;
   localparam int WIDE_W = 64;

   localparam logic [2:0] CMD_ADD       = 3'd0;
   localparam logic [2:0] CMD_SUBTRACT  = 3'd1;
   localparam logic [2:0] CMD_MULTIPLY  = 3'd2;
   localparam logic [2:0] CMD_DIVIDE    = 3'd3;
   localparam logic [2:0] CMD_NEGATE    = 3'd4;
   localparam logic [2:0] CMD_NORMALIZE = 3'd5;
   localparam logic [2:0] CMD_EQUAL     = 3'd6;
   localparam logic [2:0] CMD_UNUSED    = 3'd7;

   typedef struct packed {
      logic [2:0]                cmd;
      logic                      unused_cmd;
      logic                      uses_b;
      logic                      zero_den;
      logic signed [DATA_W-1:0]  a_num;
      logic signed [DATA_W-1:0]  a_den;
      logic signed [DATA_W-1:0]  b_num;
      logic signed [DATA_W-1:0]  b_den;
   } item_type;

   typedef enum logic [1:0] {
      RED_IDLE,
      RED_GCD,
      RED_DIV
   } red_state_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_RED_A,
      SEQ_RED_B,
      SEQ_MUL0,
      SEQ_MUL1,
      SEQ_MUL2,
      SEQ_SUM,
      SEQ_RED_F
   } seq_state_type;

endpackage

### hdl/rau_front.sv
// Front end: takes operands to the configured width and classifies each item.
module rau_front #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                              start,
   input  logic                              queue_full,
   input  logic [2:0]                        req_command,
   input  logic signed [rau_pkg::DATA_W-1:0] req_a_num,
   input  logic signed [rau_pkg::DATA_W-1:0] req_a_den,
   input  logic signed [rau_pkg::DATA_W-1:0] req_b_num,
   input  logic signed [rau_pkg::DATA_W-1:0] req_b_den,
   output logic                              push,
   output rau_pkg::item_type                 item
);

   // The most negative value is moved up by one so that every product fits.
   function automatic logic signed [rau_pkg::DATA_W-1:0] take_operand(
      input logic [rau_pkg::DATA_W-1:0] raw);
      logic signed [OPERAND_WIDTH-1:0] low;
      low = raw[OPERAND_WIDTH-1:0];
      if (low == {1'b1, {(OPERAND_WIDTH-1){1'b0}}}) begin
         low[0] = 1'b1;
      end
      return rau_pkg::DATA_W'(low);
   endfunction

   always_comb begin
      item.cmd        = req_command;
      item.a_num      = take_operand(req_a_num);
      item.a_den      = take_operand(req_a_den);
      item.b_num      = take_operand(req_b_num);
      item.b_den      = take_operand(req_b_den);
      item.unused_cmd = (req_command == rau_pkg::CMD_UNUSED);
      item.uses_b     = (req_command == rau_pkg::CMD_ADD) ||
                        (req_command == rau_pkg::CMD_SUBTRACT) ||
                        (req_command == rau_pkg::CMD_MULTIPLY) ||
                        (req_command == rau_pkg::CMD_DIVIDE) ||
                        (req_command == rau_pkg::CMD_EQUAL);
      item.zero_den   = (item.a_den == '0) || (item.uses_b && (item.b_den == '0));
      push            = start && !queue_full;
   end

endmodule

### hdl/rau_queue.sv
// Two-entry queue between the front end and the sequencer.
module rau_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rau_pkg::item_type push_item,
   input  logic              pop,
   output rau_pkg::item_type head,
   output logic              empty,
   output logic              full
);

   rau_pkg::item_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   always_comb begin
      empty     = (count_ff == 2'd0);
      full      = (count_ff == 2'd2);
      head      = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hdl/rau_reduce.sv
// Fraction reduction: binary gcd followed by a two-lane restoring division.
module rau_reduce (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [rau_pkg::WIDE_W-1:0] num,
   input  logic signed [rau_pkg::WIDE_W-1:0] den,
   output logic                              done,
   output logic signed [rau_pkg::WIDE_W-1:0] q_num,
   output logic [rau_pkg::WIDE_W-1:0]        q_den
);

   localparam int W = rau_pkg::WIDE_W;

   rau_pkg::red_state_type state_ff, state_in;
   logic [W-1:0] x_ff, x_in, y_ff, y_in, g_ff, g_in;
   logic [W-1:0] quo_a_ff, quo_a_in, quo_b_ff, quo_b_in;
   logic [W-1:0] rem_a_ff, rem_a_in, rem_b_ff, rem_b_in;
   logic [5:0]   k_ff, k_in, cnt_ff, cnt_in;
   logic         neg_ff, neg_in, done_ff, done_in;
   logic [W-1:0] sh_a, sh_b, num_mag, den_mag;

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      g_in     = g_ff;
      k_in     = k_ff;
      quo_a_in = quo_a_ff;
      quo_b_in = quo_b_ff;
      rem_a_in = rem_a_ff;
      rem_b_in = rem_b_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      num_mag  = num[W-1] ? W'(-num) : W'(num);
      den_mag  = den[W-1] ? W'(-den) : W'(den);
      sh_a     = {rem_a_ff[W-2:0], quo_a_ff[W-1]};
      sh_b     = {rem_b_ff[W-2:0], quo_b_ff[W-1]};
      unique case (state_ff)
         rau_pkg::RED_IDLE: begin
            if (start) begin
               x_in     = num_mag;
               y_in     = den_mag;
               quo_a_in = num_mag;
               quo_b_in = den_mag;
               k_in     = '0;
               neg_in   = num[W-1] != den[W-1];
               state_in = rau_pkg::RED_GCD;
            end
         end
         rau_pkg::RED_GCD: begin
            if (x_ff == '0 || y_ff == '0) begin
               g_in     = (x_ff | y_ff) << k_ff;
               rem_a_in = '0;
               rem_b_in = '0;
               cnt_in   = '0;
               state_in = rau_pkg::RED_DIV;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 6'd1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               x_in = x_ff - y_ff;
            end else begin
               y_in = y_ff - x_ff;
            end
         end
         rau_pkg::RED_DIV: begin
            quo_a_in = {quo_a_ff[W-2:0], 1'b0};
            quo_b_in = {quo_b_ff[W-2:0], 1'b0};
            rem_a_in = sh_a;
            rem_b_in = sh_b;
            if (sh_a >= g_ff) begin
               rem_a_in    = sh_a - g_ff;
               quo_a_in[0] = 1'b1;
            end
            if (sh_b >= g_ff) begin
               rem_b_in    = sh_b - g_ff;
               quo_b_in[0] = 1'b1;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               done_in  = 1'b1;
               state_in = rau_pkg::RED_IDLE;
            end
         end
         default: state_in = rau_pkg::RED_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::RED_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      g_ff     <= g_in;
      k_ff     <= k_in;
      quo_a_ff <= quo_a_in;
      quo_b_ff <= quo_b_in;
      rem_a_ff <= rem_a_in;
      rem_b_ff <= rem_b_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
   end

   // A zero numerator never carries a sign.
   assign done  = done_ff;
   assign q_num = (neg_ff && quo_a_ff != '0) ? -$signed(quo_a_ff) : $signed(quo_a_ff);
   assign q_den = quo_b_ff;

endmodule

### hdl/rau_back.sv
// Sequencer: reduces the operands, forms the cross products and the result.
module rau_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              queue_empty,
   input  rau_pkg::item_type                 head,
   output logic                              pop,
   output logic                              rsp_strobe,
   output logic signed [rau_pkg::WIDE_W-1:0] rsp_res_num,
   output logic [rau_pkg::WIDE_W-2:0]        rsp_res_den,
   output logic                              rsp_zero_den,
   output logic                              rsp_equal
);

   localparam int W = rau_pkg::WIDE_W;
   localparam int D = rau_pkg::DATA_W;

   rau_pkg::seq_state_type state_ff, state_in;
   rau_pkg::item_type      item_ff, item_in;
   logic signed [D-1:0] ra_ff, ra_in, rad_ff, rad_in, rb_ff, rb_in, rbd_ff, rbd_in;
   logic signed [W-1:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic signed [D-1:0] mul_x, mul_y;
   logic signed [W-1:0] prod, sum_n, sum_d;
   logic signed [W-1:0] red_n, red_d, q_num;
   logic [W-1:0]        q_den;
   logic                red_start, red_done;
   logic                strobe_ff, strobe_in, zden_ff, zden_in, eq_ff, eq_in;
   logic signed [W-1:0] num_ff, num_in;
   logic [W-2:0]        den_ff, den_in;

   rau_reduce u_reduce (
      .clock (clock),
      .reset (reset),
      .start (red_start),
      .num   (red_n),
      .den   (red_d),
      .done  (red_done),
      .q_num (q_num),
      .q_den (q_den)
   );

   always_comb begin
      mul_x = ra_ff;
      mul_y = rbd_ff;
      unique case (state_ff)
         rau_pkg::SEQ_MUL0: begin
            mul_x = ra_ff;
            mul_y = (item_ff.cmd == rau_pkg::CMD_MULTIPLY) ? rb_ff : rbd_ff;
         end
         rau_pkg::SEQ_MUL1: begin
            mul_x = rad_ff;
            mul_y = rb_ff;
         end
         rau_pkg::SEQ_MUL2: begin
            mul_x = rad_ff;
            mul_y = (item_ff.cmd == rau_pkg::CMD_DIVIDE) ? rb_ff : rbd_ff;
         end
         default: ;
      endcase
      prod = mul_x * mul_y;

      case (item_ff.cmd)
         rau_pkg::CMD_ADD:      sum_n = p0_ff + p1_ff;
         rau_pkg::CMD_SUBTRACT: sum_n = p0_ff - p1_ff;
         rau_pkg::CMD_MULTIPLY,
         rau_pkg::CMD_DIVIDE:   sum_n = p0_ff;
         rau_pkg::CMD_NEGATE:   sum_n = -W'(ra_ff);
         default:               sum_n = W'(ra_ff);
      endcase
      sum_d = (item_ff.cmd <= rau_pkg::CMD_DIVIDE) ? p2_ff : W'(rad_ff);
   end

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      ra_in     = ra_ff;
      rad_in    = rad_ff;
      rb_in     = rb_ff;
      rbd_in    = rbd_ff;
      p0_in     = p0_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      pop       = 1'b0;
      red_start = 1'b0;
      red_n     = W'(head.a_num);
      red_d     = W'(head.a_den);
      strobe_in = 1'b0;
      num_in    = num_ff;
      den_in    = den_ff;
      zden_in   = zden_ff;
      eq_in     = eq_ff;
      unique case (state_ff)
         rau_pkg::SEQ_IDLE: begin
            if (!queue_empty) begin
               pop     = 1'b1;
               item_in = head;
               if (head.unused_cmd) begin
                  strobe_in = 1'b1;
                  num_in    = '0;
                  den_in    = (W-1)'(1);
                  zden_in   = 1'b0;
                  eq_in     = 1'b0;
               end else if (head.zero_den) begin
                  strobe_in = 1'b1;
                  num_in    = '0;
                  den_in    = '0;
                  zden_in   = 1'b1;
                  eq_in     = 1'b0;
               end else begin
                  red_start = 1'b1;
                  state_in  = rau_pkg::SEQ_RED_A;
               end
            end
         end
         rau_pkg::SEQ_RED_A: begin
            red_n = W'(item_ff.b_num);
            red_d = W'(item_ff.b_den);
            if (red_done) begin
               ra_in  = q_num[D-1:0];
               rad_in = q_den[D-1:0];
               if (item_ff.uses_b) begin
                  red_start = 1'b1;
                  state_in  = rau_pkg::SEQ_RED_B;
               end else begin
                  state_in = rau_pkg::SEQ_MUL0;
               end
            end
         end
         rau_pkg::SEQ_RED_B: begin
            if (red_done) begin
               rb_in    = q_num[D-1:0];
               rbd_in   = q_den[D-1:0];
               state_in = rau_pkg::SEQ_MUL0;
            end
         end
         rau_pkg::SEQ_MUL0: begin
            p0_in    = prod;
            state_in = rau_pkg::SEQ_MUL1;
         end
         rau_pkg::SEQ_MUL1: begin
            p1_in    = prod;
            state_in = rau_pkg::SEQ_MUL2;
         end
         rau_pkg::SEQ_MUL2: begin
            p2_in    = prod;
            state_in = rau_pkg::SEQ_SUM;
         end
         rau_pkg::SEQ_SUM: begin
            red_n = sum_n;
            red_d = sum_d;
            if (sum_d == '0) begin
               strobe_in = 1'b1;
               num_in    = '0;
               den_in    = '0;
               zden_in   = 1'b1;
               eq_in     = 1'b0;
               state_in  = rau_pkg::SEQ_IDLE;
            end else begin
               red_start = 1'b1;
               state_in  = rau_pkg::SEQ_RED_F;
            end
         end
         rau_pkg::SEQ_RED_F: begin
            if (red_done) begin
               strobe_in = 1'b1;
               num_in    = q_num;
               den_in    = q_den[W-2:0];
               zden_in   = 1'b0;
               eq_in     = (item_ff.cmd == rau_pkg::CMD_EQUAL) &&
                           (ra_ff == rb_ff) && (rad_ff == rbd_ff);
               state_in  = rau_pkg::SEQ_IDLE;
            end
         end
         default: state_in = rau_pkg::SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rau_pkg::SEQ_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      ra_ff   <= ra_in;
      rad_ff  <= rad_in;
      rb_ff   <= rb_in;
      rbd_ff  <= rbd_in;
      p0_ff   <= p0_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      zden_ff <= zden_in;
      eq_ff   <= eq_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_res_num  = num_ff;
   assign rsp_res_den  = den_ff;
   assign rsp_zero_den = zden_ff;
   assign rsp_equal    = eq_ff;

   a_zero_den_form: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && zden_ff |-> num_ff == '0 && den_ff == '0 && !eq_ff)
      else $error("flagged result is not 0/0");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && !zden_ff |-> den_ff != '0)
      else $error("unflagged result has a zero denominator");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      red_start |=> !red_done)
      else $error("reduction finished right after it was started");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == rau_pkg::SEQ_IDLE && !queue_empty)
      else $error("item taken from the queue while busy");

endmodule

### hdl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
// An item is taken when start is high and busy is low; busy rises only when the two-entry
// queue behind the front end is full. Each item yields exactly one result, shown for one
// cycle with rsp_strobe, and the receiver cannot stall it. An unused command or a zero input
// denominator answers in the cycle after it leaves the queue. Otherwise one shared
// reduction unit runs two or three times (operand a, operand b when used, the result), each
// run being a binary gcd of one step a cycle followed by a two-lane restoring division;
// the multiply states MUL0, MUL1 and MUL2 and the sum state lie between.
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [2:0]                        req_command,
   input  logic signed [rau_pkg::DATA_W-1:0] req_a_num,
   input  logic signed [rau_pkg::DATA_W-1:0] req_a_den,
   input  logic signed [rau_pkg::DATA_W-1:0] req_b_num,
   input  logic signed [rau_pkg::DATA_W-1:0] req_b_den,
   output logic                              rsp_strobe,
   output logic signed [rau_pkg::WIDE_W-1:0] rsp_res_num,
   output logic [rau_pkg::WIDE_W-2:0]        rsp_res_den,
   output logic                              rsp_zero_den,
   output logic                              rsp_equal
);

   rau_pkg::item_type push_item, head;
   logic              push, pop, empty, full;

   rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
      .start       (start),
      .queue_full  (full),
      .req_command (req_command),
      .req_a_num   (req_a_num),
      .req_a_den   (req_a_den),
      .req_b_num   (req_b_num),
      .req_b_den   (req_b_den),
      .push        (push),
      .item        (push_item)
   );

   rau_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   rau_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_empty  (empty),
      .head         (head),
      .pop          (pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_res_num  (rsp_res_num),
      .rsp_res_den  (rsp_res_den),
      .rsp_zero_den (rsp_zero_den),
      .rsp_equal    (rsp_equal)
   );

   assign busy = full;

endmodule

### dv/tb_top.sv
// Self-checking testbench for the rational arithmetic unit, with its own fraction predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         SETTLE_CYCLES = 700;

   typedef struct {
      longint       num;
      logic [62:0]  den;
      logic         zero_den;
      logic         equal;
   } fraction_result_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic [2:0]                        req_command = rau_pkg::CMD_ADD;
   logic signed [rau_pkg::DATA_W-1:0] req_a_num = '0;
   logic signed [rau_pkg::DATA_W-1:0] req_a_den = '0;
   logic signed [rau_pkg::DATA_W-1:0] req_b_num = '0;
   logic signed [rau_pkg::DATA_W-1:0] req_b_den = '0;
   logic                              rsp_strobe;
   logic signed [rau_pkg::WIDE_W-1:0] rsp_res_num;
   logic [rau_pkg::WIDE_W-2:0]        rsp_res_den;
   logic                              rsp_zero_den;
   logic                              rsp_equal;

   fraction_result_type pending_fractions[$];
   int                  error_count = 0;

   rational_arithmetic_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // An operand is its low 32 bits; the most negative value is pulled in by one.
   function automatic longint operand_value(logic [31:0] raw);
      longint s;
      s = longint'(signed'(raw));
      if (s == -(64'sd1 <<< 31)) s = s + 1;
      return s;
   endfunction

   function automatic longint unsigned abs_value(longint v);
      return v < 0 ? 64'd0 - longint'(v) : v;
   endfunction

   function automatic void lowest_terms(input longint n, input longint d,
                                        output longint rn, output longint rd);
      longint unsigned un, ud, x, y, t;
      bit neg;
      un = abs_value(n);
      ud = abs_value(d);
      x = un;
      y = ud;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      neg = (n < 0) != (d < 0);
      un = un / x;
      ud = ud / x;
      if (un == 0) neg = 1'b0;
      rn = neg ? -longint'(un) : longint'(un);
      rd = longint'(ud);
   endfunction

   function automatic fraction_result_type fraction_outcome(
         logic [2:0] cmd, logic [31:0] a_n, logic [31:0] a_d,
         logic [31:0] b_n, logic [31:0] b_d);
      fraction_result_type r;
      longint an, ad, bn, bd, ra, rad, rb, rbd, n, d, qn, qd;
      bit uses_b;
      an = operand_value(a_n);
      ad = operand_value(a_d);
      bn = operand_value(b_n);
      bd = operand_value(b_d);
      uses_b = (cmd <= rau_pkg::CMD_DIVIDE) || (cmd == rau_pkg::CMD_EQUAL);
      r = '{num: 0, den: 0, zero_den: 1'b1, equal: 1'b0};
      rb = 0;
      rbd = 1;
      if (cmd == rau_pkg::CMD_UNUSED) begin
         r.den = 1;
         r.zero_den = 1'b0;
         return r;
      end
      if (ad == 0 || (uses_b && bd == 0)) return r;
      lowest_terms(an, ad, ra, rad);
      if (uses_b) lowest_terms(bn, bd, rb, rbd);
      case (cmd)
         rau_pkg::CMD_ADD: begin
            n = ra * rbd + rad * rb;
            d = rad * rbd;
         end
         rau_pkg::CMD_SUBTRACT: begin
            n = ra * rbd - rad * rb;
            d = rad * rbd;
         end
         rau_pkg::CMD_MULTIPLY: begin
            n = ra * rb;
            d = rad * rbd;
         end
         rau_pkg::CMD_DIVIDE: begin
            n = ra * rbd;
            d = rad * rb;
         end
         rau_pkg::CMD_NEGATE: begin
            n = -ra;
            d = rad;
         end
         rau_pkg::CMD_NORMALIZE: begin
            n = ra;
            d = rad;
         end
         default: begin
            n = ra;
            d = rad;
            r.equal = (ra == rb && rad == rbd);
         end
      endcase
      if (d == 0) begin
         r.equal = 1'b0;
         return r;
      end
      lowest_terms(n, d, qn, qd);
      r.num = qn;
      r.den = qd[62:0];
      r.zero_den = 1'b0;
      return r;
   endfunction

   // Keeps start high across a burst; the caller lowers it for a gap.
   task automatic send_fraction(logic [2:0] cmd, logic [31:0] a_n, logic [31:0] a_d,
                                logic [31:0] b_n, logic [31:0] b_d);
      @(negedge clock);
      start = 1'b1;
      req_command = cmd;
      req_a_num = a_n;
      req_a_den = a_d;
      req_b_num = b_n;
      req_b_den = b_d;
      do @(posedge clock); while (busy);
      pending_fractions.push_back(fraction_outcome(cmd, a_n, a_d, b_n, b_d));
   endtask

   task automatic pause_sender(int cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain_results();
      pause_sender(0);
      while (pending_fractions.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] random_field();
      case ($urandom_range(0, 9))
         0, 1, 2:  return 32'($signed($urandom_range(0, 2000)) - 1000);
         3:        return 32'($signed($urandom_range(0, 20)) - 10);
         4, 5, 6:  return $urandom;
         7:        return 32'd0;
         8:        return 32'h8000_0000;
         default:  return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0001;
      endcase
   endfunction

   task automatic test_corner_values();
      logic [2:0] c;
      send_fraction(rau_pkg::CMD_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
      send_fraction(rau_pkg::CMD_SUBTRACT, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'd1);
      send_fraction(rau_pkg::CMD_MULTIPLY, 32'h8000_0000, 32'h7fff_fffe,
                    32'h8000_0001, 32'h7fff_fffd);
      send_fraction(rau_pkg::CMD_DIVIDE, 32'h7fff_ffff, 32'h7fff_fffe,
                    32'h8000_0000, 32'h7fff_fffd);
      send_fraction(rau_pkg::CMD_DIVIDE, 32'd3, 32'd4, 32'd0, 32'd5);
      send_fraction(rau_pkg::CMD_ADD, 32'd1, 32'd0, 32'd1, 32'd2);
      send_fraction(rau_pkg::CMD_SUBTRACT, 32'd1, 32'd2, 32'd1, 32'd0);
      send_fraction(rau_pkg::CMD_NEGATE, 32'd6, 32'hffff_fff8, 32'd0, 32'd0);
      send_fraction(rau_pkg::CMD_NEGATE, 32'd0, 32'd7, 32'd1, 32'd1);
      send_fraction(rau_pkg::CMD_NORMALIZE, 32'hffff_fff4, 32'hffff_fff7, 32'd5, 32'd0);
      send_fraction(rau_pkg::CMD_NORMALIZE, 32'd0, 32'hffff_fffd, 32'd0, 32'd0);
      send_fraction(rau_pkg::CMD_NORMALIZE, 32'd5, 32'd0, 32'd1, 32'd1);
      send_fraction(rau_pkg::CMD_EQUAL, 32'd2, 32'd4, 32'hffff_fffd, 32'hffff_fffa);
      send_fraction(rau_pkg::CMD_EQUAL, 32'd2, 32'd4, 32'd1, 32'd3);
      send_fraction(rau_pkg::CMD_EQUAL, 32'd0, 32'd4, 32'd0, 32'hffff_ffff);
      send_fraction(rau_pkg::CMD_EQUAL, 32'd1, 32'd2, 32'd1, 32'd0);
      send_fraction(rau_pkg::CMD_UNUSED, 32'd9, 32'd0, 32'd7, 32'd0);
      send_fraction(rau_pkg::CMD_MULTIPLY, 32'd0, 32'h8000_0000, 32'h7fff_ffff, 32'd3);
      // Operand b is ignored by a unary command, whatever it holds.
      send_fraction(rau_pkg::CMD_NEGATE, 32'h8000_0000, 32'h8000_0000,
                    32'hffff_ffff, 32'hffff_ffff);
      for (int i = 0; i < 3; i++) begin
         c = 3'($urandom_range(0, 7));
         send_fraction(c, $urandom, $urandom, $urandom, $urandom);
      end
      drain_results();
   endtask

   task automatic test_random_operations(int count);
      int burst;
      for (int i = 0; i < count; i += burst) begin
         burst = $urandom_range(1, 12);
         for (int j = 0; j < burst; j++)
            send_fraction($urandom_range(0, 19) == 0 ? rau_pkg::CMD_UNUSED
                                                     : 3'($urandom_range(0, 6)),
                          random_field(), random_field(), random_field(), random_field());
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(0, 400));
         if ($urandom_range(0, 49) == 0) drain_results();
      end
      drain_results();
   endtask

   // b is a scaled copy of a, so equality holds unless the scale is broken on purpose.
   task automatic test_equal_fractions(int count);
      int n, d, k;
      for (int i = 0; i < count; i++) begin
         n = $signed($urandom_range(0, 200000)) - 100000;
         d = $signed($urandom_range(1, 100000)) * ($urandom_range(0, 1) ? 1 : -1);
         k = $signed($urandom_range(1, 20000)) * ($urandom_range(0, 1) ? 1 : -1);
         if ($urandom_range(0, 4) == 0)
            send_fraction(rau_pkg::CMD_EQUAL, n, d, n * k + 1, d * k);
         else
            send_fraction(rau_pkg::CMD_EQUAL, n, d, n * k, d * k);
         if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(0, 300));
      end
      drain_results();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_fractions.size() == 0) begin
            $display("%0t: unexpected result %0d/%0d", $time, rsp_res_num, rsp_res_den);
            error_count++;
         end else begin
            fraction_result_type e;
            e = pending_fractions.pop_front();
            if (rsp_res_num !== e.num) begin
               $display("%0t: res_num expected %0d actual %0d", $time, e.num, rsp_res_num);
               error_count++;
            end
            if (rsp_res_den !== e.den) begin
               $display("%0t: res_den expected %0d actual %0d", $time, e.den, rsp_res_den);
               error_count++;
            end
            if (rsp_zero_den !== e.zero_den) begin
               $display("%0t: zero_den expected %b actual %b", $time, e.zero_den,
                        rsp_zero_den);
               error_count++;
            end
            if (rsp_equal !== e.equal) begin
               $display("%0t: equal expected %b actual %b", $time, e.equal, rsp_equal);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (4) @(negedge clock);
      reset = 1'b0;
      test_corner_values();
      test_random_operations(1600);
      test_equal_fractions(200);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_fractions.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #40ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### files.f
hdl/rau_pkg.sv
hdl/rau_front.sv
hdl/rau_queue.sv
hdl/rau_reduce.sv
hdl/rau_back.sv
hdl/rational_arithmetic_unit.sv
dv/tb_top.sv
